// File: rtl/tcc_pkg.sv
// Shared types and constants of the text console cursor engine.
`default_nettype none
package tcc_pkg;

    localparam int COL_W = 7;
    localparam int ROW_W = 5;

    localparam int DEF_SCREEN_COLUMNS = 80;
    localparam int DEF_SCREEN_ROWS    = 25;
    localparam int DEF_QUEUE_DEPTH    = 4;

    // command codes
    localparam logic [2:0] CMD_PUT_CHAR     = 3'd0;
    localparam logic [2:0] CMD_SET_CURSOR   = 3'd1;
    localparam logic [2:0] CMD_SHOW_CURSOR  = 3'd2;
    localparam logic [2:0] CMD_HIDE_CURSOR  = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ROW    = 3'd4;
    localparam logic [2:0] CMD_CLEAR_SCREEN = 3'd5;

    // action codes
    localparam logic [2:0] ACT_CELL        = 3'd0;
    localparam logic [2:0] ACT_FILL_ROW    = 3'd1;
    localparam logic [2:0] ACT_FILL_SCREEN = 3'd2;
    localparam logic [2:0] ACT_SCROLL      = 3'd3;
    localparam logic [2:0] ACT_POS         = 3'd4;

    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_BS       = 8'h08;
    localparam logic [7:0] CHAR_BLANK    = 8'h20;
    localparam logic [7:0] CURSOR_GLYPH  = 8'hDB;
    localparam logic [7:0] CURSOR_ATTR   = 8'h0F;
    localparam logic [7:0] COLOR_RESET   = 8'h07;

    // action slots in output order; bit i of a plan's mask enables slot i
    localparam int NUM_SLOTS = 7;
    localparam logic [2:0] SLOT_ERASE       = 3'd0;
    localparam logic [2:0] SLOT_FILL_ROW    = 3'd1;
    localparam logic [2:0] SLOT_FILL_SCREEN = 3'd2;
    localparam logic [2:0] SLOT_CELL        = 3'd3;
    localparam logic [2:0] SLOT_SCROLL      = 3'd4;
    localparam logic [2:0] SLOT_POS         = 3'd5;
    localparam logic [2:0] SLOT_DRAW        = 3'd6;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] acts;
        logic [ROW_W-1:0]     old_row;
        logic [COL_W-1:0]     old_col;
        logic [ROW_W-1:0]     new_row;
        logic [COL_W-1:0]     new_col;
        logic [ROW_W-1:0]     fill_row;
        logic [7:0]           char_code;
    } plan_t;

endpackage
`default_nettype wire

// File: rtl/tcc_if.sv
// Channel interfaces: command items, action items and the color register write.
`default_nettype none
interface tcc_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] character;
    logic [7:0] target_column;
    logic [7:0] target_row;

    modport source (output valid, cmd, character, target_column, target_row, input ready);
    modport sink   (input valid, cmd, character, target_column, target_row, output ready);
endinterface

interface tcc_act_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [4:0] cell_row;
    logic [6:0] cell_column;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       last;

    modport source (output valid, action, cell_row, cell_column, cell_char, cell_attr, last,
                    input ready);
    modport sink   (input valid, action, cell_row, cell_column, cell_char, cell_attr, last,
                    output ready);
endinterface

interface tcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_color;

    modport source (output valid, text_color, input ready);
    modport sink   (input valid, text_color, output ready);
endinterface
`default_nettype wire

// File: rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine.
//
//  Channel     Dir  Payload                                          Handshake
//  command     in   cmd, character, target_column, target_row        valid/ready
//  result      out  action, cell_row, cell_column, cell_char,        valid/ready
//                   cell_attr, last
//  color_cfg   in   text_color                                       valid/ready (always ready)
//
// A command is classified in the cycle it is accepted and its plan enters a
// short queue unless it has no actions; the back end then emits one action per
// cycle while the result is not stalled, zero to five per command. The front keeps
// accepting while the queue has room. Reset puts the cursor hidden at the
// top left and text_color at 0x07. A stalled result holds its register.
`default_nettype none
module text_console_cursor_engine #(
    parameter int SCREEN_COLUMNS = tcc_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcc_pkg::DEF_SCREEN_ROWS,
    parameter int QUEUE_DEPTH    = tcc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tcc_cmd_if.sink   command,
    tcc_act_if.source result,
    tcc_cfg_if.sink   color_cfg
);
    import tcc_pkg::*;

    plan_t push_plan;
    plan_t head_plan;
    logic  push, full, pop, empty;

    tcc_front #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .command(command),
        .plan   (push_plan),
        .push   (push),
        .full   (full)
    );

    tcc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_plan(push_plan),
        .full   (full),
        .pop    (pop),
        .rd_plan(head_plan),
        .empty  (empty)
    );

    tcc_back #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_plan),
        .empty    (empty),
        .pop      (pop),
        .color_cfg(color_cfg),
        .result   (result)
    );

endmodule
`default_nettype wire

// File: rtl/tcc_front.sv
// Front end: accepts commands, tracks the cursor and turns each command into an action plan.
`default_nettype none
module tcc_front #(
    parameter int SCREEN_COLUMNS = tcc_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcc_pkg::DEF_SCREEN_ROWS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tcc_cmd_if.sink      command,
    output tcc_pkg::plan_t plan,
    output logic         push,
    input  wire logic    full
);
    import tcc_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             shown_reg, shown_next;

    logic [COL_W-1:0] tcol;
    logic [ROW_W-1:0] trow;
    logic [COL_W:0]   col_inc;
    logic             new_line;
    logic             take;

    assign take          = command.valid && !full;
    assign command.ready = !full;
    assign col_inc       = {1'b0, col_reg} + 1'b1;

    always_comb
    begin
        tcol = (command.target_column >= 8'(SCREEN_COLUMNS)) ? LAST_COL
                                                             : command.target_column[COL_W-1:0];
        trow = (command.target_row >= 8'(SCREEN_ROWS)) ? LAST_ROW
                                                       : command.target_row[ROW_W-1:0];
    end

    always_comb
    begin
        plan          = '0;
        plan.old_row  = row_reg;
        plan.old_col  = col_reg;
        plan.fill_row = trow;
        plan.char_code = command.character;
        col_next      = col_reg;
        row_next      = row_reg;
        shown_next    = shown_reg;
        new_line      = 1'b0;

        unique case (command.cmd)
            CMD_PUT_CHAR:
            begin
                plan.acts[SLOT_ERASE] = shown_reg;
                plan.acts[SLOT_DRAW]  = shown_reg;
                case (command.character)
                    CHAR_CR:
                    begin
                        col_next = '0;
                        plan.acts[SLOT_POS] = 1'b1;
                    end
                    CHAR_LF:
                    begin
                        col_next = '0;
                        new_line = 1'b1;
                    end
                    CHAR_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                            plan.acts[SLOT_POS] = 1'b1;
                        end
                    end
                    default:
                    begin
                        plan.acts[SLOT_CELL] = 1'b1;
                        if (col_inc >= (COL_W+1)'(SCREEN_COLUMNS))
                        begin
                            col_next = '0;
                            new_line = 1'b1;
                        end
                        else
                        begin
                            col_next = col_inc[COL_W-1:0];
                            plan.acts[SLOT_POS] = 1'b1;
                        end
                    end
                endcase
                if (new_line)
                begin
                    plan.acts[SLOT_POS] = 1'b1;
                    if (row_reg < LAST_ROW)
                        row_next = row_reg + 1'b1;
                    else
                        plan.acts[SLOT_SCROLL] = 1'b1;
                end
            end
            CMD_SET_CURSOR:
            begin
                plan.acts[SLOT_ERASE] = shown_reg;
                plan.acts[SLOT_POS]   = 1'b1;
                plan.acts[SLOT_DRAW]  = shown_reg;
                col_next = tcol;
                row_next = trow;
            end
            CMD_SHOW_CURSOR:
            begin
                shown_next = 1'b1;
                plan.acts[SLOT_DRAW] = 1'b1;
            end
            CMD_HIDE_CURSOR:
            begin
                shown_next = 1'b0;
                plan.acts[SLOT_ERASE] = shown_reg;
            end
            CMD_CLEAR_ROW:
            begin
                plan.acts[SLOT_FILL_ROW] = 1'b1;
                plan.acts[SLOT_DRAW]     = shown_reg && (row_reg == trow);
            end
            CMD_CLEAR_SCREEN:
            begin
                plan.acts[SLOT_FILL_SCREEN] = 1'b1;
                plan.acts[SLOT_POS]         = 1'b1;
                plan.acts[SLOT_DRAW]        = shown_reg;
                col_next = '0;
                row_next = '0;
            end
            default:
            begin
                // unused codes: drop
            end
        endcase

        plan.new_row = row_next;
        plan.new_col = col_next;
    end

    // commands with no actions never enter the queue
    assign push = take && (plan.acts != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            shown_reg <= 1'b0;
        end
        else if (take)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            shown_reg <= shown_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tcc_queue.sv
// Short queue of action plans between the front and back ends.
`default_nettype none
module tcc_queue #(
    parameter int DEPTH = tcc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tcc_pkg::plan_t wr_plan,
    output logic                full,
    input  wire logic           pop,
    output tcc_pkg::plan_t      rd_plan,
    output logic                empty
);
    import tcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    plan_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_plan = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_plan;
    end

endmodule
`default_nettype wire

// File: rtl/tcc_back.sv
// Back end: walks each plan slot by slot and emits one action item per cycle while the result is not stalled.
`default_nettype none
module tcc_back #(
    parameter int SCREEN_COLUMNS = tcc_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = tcc_pkg::DEF_SCREEN_ROWS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tcc_pkg::plan_t head,
    input  wire logic           empty,
    output logic                pop,
    tcc_cfg_if.sink             color_cfg,
    tcc_act_if.source           result
);
    import tcc_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

    logic [7:0]           color_reg;
    plan_t                cur_reg, cur_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [NUM_SLOTS-1:0] sel, rest;
    logic [2:0]           slot;

    logic                 valid_reg, valid_next;
    logic [2:0]           action_reg, action_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [7:0]           char_reg, char_next;
    logic [7:0]           attr_reg, attr_next;
    logic                 last_reg, last_next;
    logic                 advance;

    assign color_cfg.ready = 1'b1;

    // lowest pending slot goes out first
    always_comb
    begin
        slot = SLOT_DRAW;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                slot = 3'(i);
        end
        sel  = NUM_SLOTS'(1) << slot;
        rest = mask_reg & ~sel;
    end

    assign advance = (mask_reg != '0) && (!valid_reg || result.ready);
    assign pop     = !empty && ((mask_reg == '0) || (advance && rest == '0));

    always_comb
    begin
        cur_next    = cur_reg;
        mask_next   = mask_reg;
        valid_next  = valid_reg;
        action_next = action_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        char_next   = char_reg;
        attr_next   = attr_reg;
        last_next   = last_reg;

        if (result.ready)
            valid_next = 1'b0;

        if (advance)
        begin
            mask_next  = rest;
            valid_next = 1'b1;
            last_next  = (rest == '0);
            attr_next  = color_reg;
            char_next  = CHAR_BLANK;
            unique case (slot)
                SLOT_ERASE:
                begin
                    action_next = ACT_CELL;
                    row_next    = cur_reg.old_row;
                    col_next    = cur_reg.old_col;
                end
                SLOT_FILL_ROW:
                begin
                    action_next = ACT_FILL_ROW;
                    row_next    = cur_reg.fill_row;
                    col_next    = '0;
                end
                SLOT_FILL_SCREEN:
                begin
                    action_next = ACT_FILL_SCREEN;
                    row_next    = '0;
                    col_next    = '0;
                end
                SLOT_CELL:
                begin
                    action_next = ACT_CELL;
                    row_next    = cur_reg.old_row;
                    col_next    = cur_reg.old_col;
                    char_next   = cur_reg.char_code;
                end
                SLOT_SCROLL:
                begin
                    action_next = ACT_SCROLL;
                    row_next    = LAST_ROW;
                    col_next    = LAST_COL;
                end
                SLOT_POS:
                begin
                    action_next = ACT_POS;
                    row_next    = cur_reg.new_row;
                    col_next    = cur_reg.new_col;
                    char_next   = '0;
                    attr_next   = '0;
                end
                default:
                begin
                    action_next = ACT_CELL;
                    row_next    = cur_reg.new_row;
                    col_next    = cur_reg.new_col;
                    char_next   = CURSOR_GLYPH;
                    attr_next   = CURSOR_ATTR;
                end
            endcase
        end

        if (pop)
        begin
            cur_next  = head;
            mask_next = head.acts;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_RESET;
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (color_cfg.valid)
                color_reg <= color_cfg.text_color;
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        action_reg <= action_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        char_reg   <= char_next;
        attr_reg   <= attr_next;
        last_reg   <= last_next;
    end

    assign result.valid       = valid_reg;
    assign result.action      = action_reg;
    assign result.cell_row    = row_reg;
    assign result.cell_column = col_reg;
    assign result.cell_char   = char_reg;
    assign result.cell_attr   = attr_reg;
    assign result.last        = last_reg;

endmodule
`default_nettype wire

// File: tb/text_console_cursor_engine_tb.sv
// Self-checking testbench for the text console cursor engine: command driver and action checker.
module text_console_cursor_engine_tb;
    import tcc_pkg::*;

    localparam int COLS = DEF_SCREEN_COLUMNS;
    localparam int ROWS = DEF_SCREEN_ROWS;

    // command codes the block must ignore
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] character;
        logic [7:0] target_column;
        logic [7:0] target_row;
    } console_cmd_t;

    typedef struct {
        logic [2:0] action;
        logic [4:0] row;
        logic [6:0] column;
        logic [7:0] ch;
        logic [7:0] attr;
        logic       last;
    } screen_action_t;

    logic clk = 1'b0;
    logic rst_n;

    tcc_cmd_if command_ch ();
    tcc_act_if result_ch ();
    tcc_cfg_if color_ch ();

    text_console_cursor_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command_ch),
        .result    (result_ch),
        .color_cfg (color_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted console state
    logic [6:0] cur_col   = '0;
    logic [4:0] cur_row   = '0;
    logic       cur_shown = 1'b0;
    logic [7:0] cur_color = COLOR_RESET;

    console_cmd_t   queued_cmds[$];
    screen_action_t expected_actions[$];
    console_cmd_t   offered_cmd;

    int failures     = 0;
    int cycle_count  = 0;
    int tx_gap_left  = 0;
    int rx_stall_left = 0;
    int hold_req     = 0;
    int hold_done    = 0;
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic string describe(screen_action_t a);
        return $sformatf("act=%0d row=%0d col=%0d char=%02h attr=%02h last=%0b",
                         a.action, a.row, a.column, a.ch, a.attr, a.last);
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic void push_action(logic [2:0] act, logic [4:0] r, logic [6:0] c,
                                        logic [7:0] ch, logic [7:0] attr);
        screen_action_t a;
        a.action = act;
        a.row    = r;
        a.column = c;
        a.ch     = ch;
        a.attr   = attr;
        a.last   = 1'b0;
        expected_actions.push_back(a);
    endfunction

    function automatic void push_position();
        push_action(ACT_POS, cur_row, cur_col, 8'h00, 8'h00);
    endfunction

    function automatic void erase_glyph();
        if (cur_shown)
            push_action(ACT_CELL, cur_row, cur_col, CHAR_BLANK, cur_color);
    endfunction

    function automatic void draw_glyph();
        if (cur_shown)
            push_action(ACT_CELL, cur_row, cur_col, CURSOR_GLYPH, CURSOR_ATTR);
    endfunction

    function automatic void advance_line();
        if (cur_row < 5'(ROWS - 1))
            cur_row++;
        else
            push_action(ACT_SCROLL, 5'(ROWS - 1), 7'(COLS - 1), CHAR_BLANK, cur_color);
        push_position();
    endfunction

    // Update the console state for one accepted command and queue its actions.
    function automatic void apply_command(console_cmd_t c);
        int         base;
        logic [6:0] tcol;
        logic [4:0] trow;
        base = expected_actions.size();
        tcol = (c.target_column >= COLS) ? 7'(COLS - 1) : c.target_column[6:0];
        trow = (c.target_row >= ROWS) ? 5'(ROWS - 1) : c.target_row[4:0];
        case (c.cmd)
            CMD_PUT_CHAR:
            begin
                erase_glyph();
                if (c.character == CHAR_CR)
                begin
                    cur_col = '0;
                    push_position();
                end
                else if (c.character == CHAR_LF)
                begin
                    cur_col = '0;
                    advance_line();
                end
                else if (c.character == CHAR_BS)
                begin
                    if (cur_col != 0)
                    begin
                        cur_col--;
                        push_position();
                    end
                end
                else
                begin
                    push_action(ACT_CELL, cur_row, cur_col, c.character, cur_color);
                    if (cur_col == 7'(COLS - 1))
                    begin
                        cur_col = '0;
                        advance_line();
                    end
                    else
                    begin
                        cur_col++;
                        push_position();
                    end
                end
                draw_glyph();
            end
            CMD_SET_CURSOR:
            begin
                erase_glyph();
                cur_col = tcol;
                cur_row = trow;
                push_position();
                draw_glyph();
            end
            CMD_SHOW_CURSOR:
            begin
                cur_shown = 1'b1;
                draw_glyph();
            end
            CMD_HIDE_CURSOR:
            begin
                if (cur_shown)
                begin
                    cur_shown = 1'b0;
                    push_action(ACT_CELL, cur_row, cur_col, CHAR_BLANK, cur_color);
                end
            end
            CMD_CLEAR_ROW:
            begin
                push_action(ACT_FILL_ROW, trow, 7'd0, CHAR_BLANK, cur_color);
                if (cur_row == trow)
                    draw_glyph();
            end
            CMD_CLEAR_SCREEN:
            begin
                push_action(ACT_FILL_SCREEN, 5'd0, 7'd0, CHAR_BLANK, cur_color);
                cur_col = '0;
                cur_row = '0;
                push_position();
                draw_glyph();
            end
            default:
                ;
        endcase
        if (expected_actions.size() > base)
            expected_actions[$].last = 1'b1;
    endfunction

    function automatic void queue_cmd(logic [2:0] cmd, logic [7:0] ch, logic [7:0] tc,
                                      logic [7:0] tr);
        console_cmd_t c;
        c.cmd           = cmd;
        c.character     = ch;
        c.target_column = tc;
        c.target_row    = tr;
        queued_cmds.push_back(c);
    endfunction

    // mostly on screen, often at the far edge, sometimes past it
    function automatic logic [7:0] random_target(int limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(0, limit - 1));
        if (r < 80)
            return 8'($urandom_range(limit - 3, limit - 1));
        return 8'($urandom_range(limit, 255));
    endfunction

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CHAR_CR;
        if (r < 20)
            return CHAR_LF;
        if (r < 30)
            return CHAR_BS;
        return 8'($urandom);
    endfunction

    function automatic void queue_random_commands(int wanted);
        int         count;
        int         r;
        int         n;
        logic [2:0] cmd;
        count = 0;
        while (count < wanted)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                // park near the right edge, then type across the wrap
                queue_cmd(CMD_SET_CURSOR, 8'($urandom), 8'($urandom_range(COLS - 4, COLS - 1)),
                          random_target(ROWS));
                n = $urandom_range(2, 6);
                repeat (n)
                    queue_cmd(CMD_PUT_CHAR, random_char(), 8'($urandom), 8'($urandom));
                count += n + 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    cmd = CMD_PUT_CHAR;
                else if (r < 55)
                    cmd = CMD_SET_CURSOR;
                else if (r < 67)
                    cmd = CMD_SHOW_CURSOR;
                else if (r < 78)
                    cmd = CMD_HIDE_CURSOR;
                else if (r < 89)
                    cmd = CMD_CLEAR_ROW;
                else if (r < 95)
                    cmd = CMD_CLEAR_SCREEN;
                else if (r < 98)
                    cmd = CMD_SPARE_6;
                else
                    cmd = CMD_SPARE_7;
                queue_cmd(cmd, random_char(), random_target(COLS), random_target(ROWS));
                if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7)
                    count++;
            end
        end
    endfunction

    // Hold until every queued command is in and every action is out, then let
    // the block drain with no new commands offered.
    task automatic wait_idle();
        while (queued_cmds.size() != 0 || command_ch.valid || expected_actions.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_color(logic [7:0] value);
        @(posedge clk);
        color_ch.valid      <= 1'b1;
        color_ch.text_color <= value;
        do
            @(posedge clk);
        while (!color_ch.ready);
        cur_color = value;
        color_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            command_ch.valid <= 1'b0;
        end
        else
        begin
            if (command_ch.valid && command_ch.ready)
                apply_command(offered_cmd);
            if (!command_ch.valid || command_ch.ready)
            begin
                if (tx_gap_left > 0)
                begin
                    tx_gap_left--;
                    command_ch.valid <= 1'b0;
                end
                else if (queued_cmds.size() != 0)
                begin
                    offered_cmd = queued_cmds.pop_front();
                    command_ch.valid         <= 1'b1;
                    command_ch.cmd           <= offered_cmd.cmd;
                    command_ch.character     <= offered_cmd.character;
                    command_ch.target_column <= offered_cmd.target_column;
                    command_ch.target_row    <= offered_cmd.target_row;
                    tx_gap_left = tx_quiet ? 0 : pick_gap();
                end
                else
                begin
                    command_ch.valid <= 1'b0;
                end
            end
        end
    end

    // action checker and receiver stalls
    always @(posedge clk)
    begin
        screen_action_t got;
        screen_action_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.action = result_ch.action;
                got.row    = result_ch.cell_row;
                got.column = result_ch.cell_column;
                got.ch     = result_ch.cell_char;
                got.attr   = result_ch.cell_attr;
                got.last   = result_ch.last;
                if (expected_actions.size() == 0)
                begin
                    note_failure($sformatf("%0t: unexpected action, expected none, actual %s",
                                           $time, describe(got)));
                end
                else
                begin
                    want = expected_actions.pop_front();
                    if (got.action !== want.action || got.row !== want.row ||
                        got.column !== want.column || got.ch !== want.ch ||
                        got.attr !== want.attr || got.last !== want.last)
                        note_failure($sformatf("%0t: action mismatch, expected %s, actual %s",
                                               $time, describe(want), describe(got)));
                end
            end
            if (hold_done != hold_req)
            begin
                hold_done = hold_req;
                rx_stall_left = HOLD_CYCLES;
            end
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!rx_quiet)
                    rx_stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        command_ch.valid         = 1'b0;
        command_ch.cmd           = CMD_PUT_CHAR;
        command_ch.character     = 8'h00;
        command_ch.target_column = 8'h00;
        command_ch.target_row    = 8'h00;
        result_ch.ready          = 1'b0;
        color_ch.valid           = 1'b0;
        color_ch.text_color      = 8'h00;
        rst_n                    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, text color at its reset value
        queue_cmd(CMD_PUT_CHAR, 8'h41, 8'h00, 8'h00);
        queue_cmd(CMD_PUT_CHAR, CHAR_BS, 8'h00, 8'h00);
        queue_cmd(CMD_PUT_CHAR, CHAR_BS, 8'hFF, 8'hFF);     // column zero, hidden: nothing
        queue_cmd(CMD_HIDE_CURSOR, 8'h00, 8'h00, 8'h00);    // already hidden: nothing
        queue_cmd(CMD_SPARE_6, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(CMD_SPARE_7, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(CMD_SHOW_CURSOR, 8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_SHOW_CURSOR, 8'hFF, 8'hFF, 8'hFF);    // shown again: redraw
        queue_cmd(CMD_SET_CURSOR, 8'h00, 8'hFF, 8'hFF);     // clamp to bottom right
        queue_cmd(CMD_PUT_CHAR, 8'hFF, 8'h00, 8'h00);       // wrap and scroll
        queue_cmd(CMD_PUT_CHAR, CHAR_LF, 8'h00, 8'h00);     // line feed on last row
        queue_cmd(CMD_PUT_CHAR, 8'h55, 8'h00, 8'h00);
        queue_cmd(CMD_PUT_CHAR, CHAR_CR, 8'h00, 8'h00);
        queue_cmd(CMD_SET_CURSOR, 8'h00, 8'(COLS - 1), 8'd3);
        queue_cmd(CMD_PUT_CHAR, 8'h00, 8'h00, 8'h00);       // wrap mid-screen
        queue_cmd(CMD_CLEAR_ROW, 8'h00, 8'h00, 8'd4);       // cursor on that row
        queue_cmd(CMD_PUT_CHAR, CHAR_BS, 8'h00, 8'h00);     // column zero, shown
        queue_cmd(CMD_CLEAR_ROW, 8'h00, 8'h00, 8'hFF);      // clamped, cursor elsewhere
        queue_cmd(CMD_SET_CURSOR, 8'h00, 8'(COLS), 8'(ROWS));
        queue_cmd(CMD_SET_CURSOR, 8'hAA, 8'h00, 8'h00);
        queue_cmd(CMD_PUT_CHAR, CHAR_LF, 8'h00, 8'h00);
        queue_cmd(CMD_CLEAR_SCREEN, 8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_HIDE_CURSOR, 8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_CLEAR_ROW, 8'h00, 8'h00, 8'h00);      // hidden cursor on that row
        queue_cmd(CMD_PUT_CHAR, 8'hAA, 8'h55, 8'hAA);
        wait_idle();

        write_color(8'hFF);
        queue_random_commands(19);
        wait_idle();

        // keep offering while the receiver holds off, so the block backs up
        write_color(8'h00);
        tx_quiet = 1'b1;
        queue_random_commands(19);
        hold_req++;
        wait_idle();
        tx_quiet = 1'b0;

        write_color(8'($urandom));
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        queue_random_commands(19);
        wait_idle();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        write_color(8'($urandom));
        queue_random_commands(19);
        wait_idle();

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
